FILE: rtl/tor_pkg.sv
// shared types, constants and helpers for the tap onset peak recorder
`timescale 1ns / 1ps

package tor_pkg;

    localparam int TIME_W     = 24;
    localparam int PROD_W     = TIME_W + 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // peak / 27 as (peak * 19) >> 9, exact for every 8-bit peak
    localparam int STRENGTH_MUL   = 19;
    localparam int STRENGTH_SHIFT = 9;
    localparam int STRENGTH_PW    = 13;

    localparam logic [7:0]  ON_LEVEL_RST    = 8'd30;
    localparam logic [7:0]  OFF_LEVEL_RST   = 8'd30;
    localparam logic [7:0]  TICK_MS_RST     = 8'd5;
    localparam logic [15:0] SILENCE_MS_RST  = 16'd2000;
    localparam logic [15:0] LOOP_PAD_MS_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_LEVEL    = 3'd0,
        REG_OFF_LEVEL   = 3'd1,
        REG_TICK_MS     = 3'd2,
        REG_SILENCE_MS  = 3'd3,
        REG_LOOP_PAD_MS = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  on_level;
        logic [7:0]  off_level;
        logic [7:0]  tick_ms;
        logic [15:0] silence_ms;
        logic [15:0] loop_pad_ms;
    } cfg_t;

    typedef struct packed {
        logic       cmd;
        logic       sample_valid;
        logic [7:0] sample;
    } item_t;

    typedef struct packed {
        logic              stop_request;
        logic              tap_valid;
        logic [3:0]        tap_strength;
        logic [TIME_W-1:0] tap_time;
        logic              record_done;
        logic [TIME_W-1:0] loop_length;
        logic              recording_now;
        logic              ready_now;
        logic              playing_now;
    } result_t;

    function automatic logic [3:0] strength_of(input logic [7:0] peak);
        logic [STRENGTH_PW-1:0] prod;
        prod = STRENGTH_PW'(peak) * STRENGTH_PW'(STRENGTH_MUL);
        return 4'(prod >> STRENGTH_SHIFT);
    endfunction

endpackage

FILE: rtl/tor_cfg.sv
// configuration register file
`timescale 1ns / 1ps

module tor_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tor_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tor_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tor_pkg::cfg_t                   cfg
);

    tor_pkg::cfg_t cfg_reg;
    tor_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (tor_pkg::cfg_idx_t'(cfg_index))
                tor_pkg::REG_ON_LEVEL:    cfg_next.on_level    = cfg_wdata[7:0];
                tor_pkg::REG_OFF_LEVEL:   cfg_next.off_level   = cfg_wdata[7:0];
                tor_pkg::REG_TICK_MS:     cfg_next.tick_ms     = cfg_wdata[7:0];
                tor_pkg::REG_SILENCE_MS:  cfg_next.silence_ms  = cfg_wdata;
                tor_pkg::REG_LOOP_PAD_MS: cfg_next.loop_pad_ms = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_level    <= tor_pkg::ON_LEVEL_RST;
            cfg_reg.off_level   <= tor_pkg::OFF_LEVEL_RST;
            cfg_reg.tick_ms     <= tor_pkg::TICK_MS_RST;
            cfg_reg.silence_ms  <= tor_pkg::SILENCE_MS_RST;
            cfg_reg.loop_pad_ms <= tor_pkg::LOOP_PAD_MS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tor_step.sv
// detector state and the single-pass step logic for one request
`timescale 1ns / 1ps

module tor_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  tor_pkg::item_t    item,
    input  tor_pkg::cfg_t     cfg,
    output tor_pkg::result_t  result
);

    logic [7:0]                 held_sample_reg, held_sample_next;
    logic                       tap_open_reg, tap_open_next;
    logic                       recording_reg, recording_next;
    logic [7:0]                 peak_value_reg, peak_value_next;
    logic [tor_pkg::TIME_W-1:0] peak_time_reg, peak_time_next;
    logic [tor_pkg::TIME_W-1:0] tick_count_reg, tick_count_next;
    logic                       has_tap_reg, has_tap_next;
    logic [tor_pkg::TIME_W-1:0] last_tap_time_reg, last_tap_time_next;
    logic                       ready_reg, ready_next;
    logic                       playing_reg, playing_next;

    logic [tor_pkg::PROD_W-1:0] now_prod;
    logic [tor_pkg::TIME_W-1:0] now_ms;

    logic [7:0]                 smp;
    logic                       open_now, tap_open1, start, recording1;
    logic [7:0]                 peak1, peak2;
    logic                       upd_peak, close, emit, first;
    logic [tor_pkg::TIME_W-1:0] ptime2, ptime3, tick1, last2, now2, elapsed;
    logic                       has_tap2, exceed, recording2;
    logic [tor_pkg::TIME_W:0]   loop_sum;

    // tick_count * tick_ms, saturated
    assign now_prod = tor_pkg::PROD_W'(tick_count_reg) * tor_pkg::PROD_W'(cfg.tick_ms);
    assign now_ms   = (|now_prod[tor_pkg::PROD_W-1:tor_pkg::TIME_W]) ? tor_pkg::TIME_MAX
                                                                     : now_prod[tor_pkg::TIME_W-1:0];

    always_comb begin
        smp        = item.sample_valid ? item.sample : held_sample_reg;

        open_now   = (smp > cfg.on_level) && !tap_open_reg;
        tap_open1  = tap_open_reg | open_now;
        peak1      = open_now ? 8'd0 : peak_value_reg;
        start      = open_now && !recording_reg;
        recording1 = recording_reg | start;

        upd_peak   = tap_open1 && (peak1 < smp);
        peak2      = upd_peak ? smp : peak1;
        ptime2     = upd_peak ? now_ms : peak_time_reg;

        close      = (smp < cfg.off_level) && tap_open1;
        emit       = close && recording1;
        // first tap of a recording rebases time to zero
        first      = emit && !has_tap_reg;
        tick1      = first ? '0 : tick_count_reg;
        ptime3     = first ? '0 : ptime2;
        has_tap2   = has_tap_reg | emit;
        last2      = emit ? ptime3 : last_tap_time_reg;

        now2       = first ? '0 : now_ms;
        elapsed    = now2 - last2;
        exceed     = recording1 && has_tap2 && (now2 > last2)
                     && (elapsed > tor_pkg::TIME_W'(cfg.silence_ms));
        recording2 = recording1 & ~exceed;
        loop_sum   = (tor_pkg::TIME_W+1)'(last2) + (tor_pkg::TIME_W+1)'(cfg.loop_pad_ms);

        held_sample_next   = held_sample_reg;
        tap_open_next      = tap_open_reg;
        recording_next     = recording_reg;
        peak_value_next    = peak_value_reg;
        peak_time_next     = peak_time_reg;
        tick_count_next    = tick_count_reg;
        has_tap_next       = has_tap_reg;
        last_tap_time_next = last_tap_time_reg;
        ready_next         = ready_reg;
        playing_next       = playing_reg;
        result             = '0;

        if (item.cmd) begin
            // rhythm received: forget taps, keep recording and open tap
            playing_next       = 1'b1;
            has_tap_next       = 1'b0;
            last_tap_time_next = '0;
            tick_count_next    = '0;
            ready_next         = 1'b0;
        end else begin
            held_sample_next   = smp;
            tap_open_next      = tap_open1 & ~close;
            recording_next     = recording2;
            peak_value_next    = peak2;
            peak_time_next     = ptime3;
            has_tap_next       = has_tap2;
            last_tap_time_next = last2;
            ready_next         = ready_reg | exceed;
            playing_next       = playing_reg & ~start;
            tick_count_next    = (recording2 && (tick1 != tor_pkg::TIME_MAX))
                                 ? tick1 + tor_pkg::TIME_W'(1) : tick1;

            result.stop_request = start;
            result.tap_valid    = emit;
            result.tap_strength = emit ? tor_pkg::strength_of(peak2) : 4'd0;
            result.tap_time     = emit ? ptime3 : '0;
            result.record_done  = exceed;
            if (exceed) begin
                result.loop_length = loop_sum[tor_pkg::TIME_W] ? tor_pkg::TIME_MAX
                                                               : loop_sum[tor_pkg::TIME_W-1:0];
            end
        end

        result.recording_now = recording_next;
        result.ready_now     = ready_next;
        result.playing_now   = playing_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_sample_reg   <= '0;
            tap_open_reg      <= 1'b0;
            recording_reg     <= 1'b0;
            peak_value_reg    <= '0;
            peak_time_reg     <= '0;
            tick_count_reg    <= '0;
            has_tap_reg       <= 1'b0;
            last_tap_time_reg <= '0;
            ready_reg         <= 1'b0;
            playing_reg       <= 1'b0;
        end else if (adv) begin
            held_sample_reg   <= held_sample_next;
            tap_open_reg      <= tap_open_next;
            recording_reg     <= recording_next;
            peak_value_reg    <= peak_value_next;
            peak_time_reg     <= peak_time_next;
            tick_count_reg    <= tick_count_next;
            has_tap_reg       <= has_tap_next;
            last_tap_time_reg <= last_tap_time_next;
            ready_reg         <= ready_next;
            playing_reg       <= playing_next;
        end
    end

`ifndef SYNTH
    a_clear_forgets: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && item.cmd |=> (tick_count_reg == '0) && !has_tap_reg && !ready_reg)
        else $error("clear request did not forget taps");

    a_tap_marks_has_tap: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && result.tap_valid |=> has_tap_reg)
        else $error("emitted tap not remembered");

    a_idle_time_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !item.cmd && !recording_reg && !result.recording_now
        |=> tick_count_reg == $past(tick_count_reg))
        else $error("time moved outside a recording");

    a_hold_without_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(tick_count_reg) && $stable(recording_reg) && $stable(tap_open_reg))
        else $error("state changed without a request");
`endif

endmodule

FILE: rtl/tor_out_reg.sv
// result register with valid/ready output handshake
`timescale 1ns / 1ps

module tor_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tor_pkg::result_t  result_in,
    input  logic              m_ready,
    output logic              m_valid,
    output tor_pkg::result_t  result_q
);

    logic             valid_reg, valid_next;
    tor_pkg::result_t data_reg;

    always_comb begin
        priority if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid  = valid_reg;
    assign result_q = data_reg;

endmodule

FILE: rtl/tap_onset_peak_recorder.sv
// top level of the tap onset peak recorder
`timescale 1ns / 1ps

// Tap recorder with hysteresis onset detection and peak tracking. A request is
// taken into an input register, then the step logic updates the detector
// state and writes one result into the output register, which raises m_valid
// and holds the result until m_ready takes it. With m_ready held high the
// block takes one request per clock, back to back; a stall on the output
// side holds the input register and then drops s_ready. The longest path per
// cycle is the 24x8 multiply that turns the tick count into milliseconds,
// followed by the silence compare. Configuration writes take effect at the
// next clock edge and belong to idle periods only.

module tap_onset_peak_recorder (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic                            s_sample_valid,
    input  logic [7:0]                      s_sample,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_stop_request,
    output logic                            m_tap_valid,
    output logic [3:0]                      m_tap_strength,
    output logic [tor_pkg::TIME_W-1:0]      m_tap_time,
    output logic                            m_record_done,
    output logic [tor_pkg::TIME_W-1:0]      m_loop_length,
    output logic                            m_recording_now,
    output logic                            m_ready_now,
    output logic                            m_playing_now,

    input  logic                            cfg_wr_en,
    input  logic [tor_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tor_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic             in_valid_reg, in_valid_next;
    tor_pkg::item_t   in_item_reg;
    logic             s_fire, adv;
    tor_pkg::cfg_t    cfg;
    tor_pkg::result_t step_result;
    tor_pkg::result_t out_result;

    // step advances when a request is held and the result register is free or being drained
    assign adv     = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        priority if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.cmd          <= s_cmd;
            in_item_reg.sample_valid <= s_sample_valid;
            in_item_reg.sample       <= s_sample;
        end
    end

    tor_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tor_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    tor_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (adv),
        .result_in (step_result),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .result_q  (out_result)
    );

    assign m_stop_request  = out_result.stop_request;
    assign m_tap_valid     = out_result.tap_valid;
    assign m_tap_strength  = out_result.tap_strength;
    assign m_tap_time      = out_result.tap_time;
    assign m_record_done   = out_result.record_done;
    assign m_loop_length   = out_result.loop_length;
    assign m_recording_now = out_result.recording_now;
    assign m_ready_now     = out_result.ready_now;
    assign m_playing_now   = out_result.playing_now;

endmodule

FILE: bench/tb_tap_onset_peak_recorder.sv
// self-checking testbench for the tap onset peak recorder
`timescale 1ns / 1ps

module tb_tap_onset_peak_recorder;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int STRENGTH_DIV = 27;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 50;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_cmd;
    logic                           s_sample_valid;
    logic [7:0]                     s_sample;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_stop_request;
    logic                           m_tap_valid;
    logic [3:0]                     m_tap_strength;
    logic [tor_pkg::TIME_W-1:0]     m_tap_time;
    logic                           m_record_done;
    logic [tor_pkg::TIME_W-1:0]     m_loop_length;
    logic                           m_recording_now;
    logic                           m_ready_now;
    logic                           m_playing_now;
    logic                           cfg_wr_en;
    logic [tor_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tor_pkg::CFG_DATA_W-1:0] cfg_wdata;

    tap_onset_peak_recorder u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_sample_valid  (s_sample_valid),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_stop_request  (m_stop_request),
        .m_tap_valid     (m_tap_valid),
        .m_tap_strength  (m_tap_strength),
        .m_tap_time      (m_tap_time),
        .m_record_done   (m_record_done),
        .m_loop_length   (m_loop_length),
        .m_recording_now (m_recording_now),
        .m_ready_now     (m_ready_now),
        .m_playing_now   (m_playing_now),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // recorder state as the bench sees it
    tor_pkg::cfg_t              regs;
    logic [7:0]                 held_smp;
    logic [7:0]                 peak_val;
    logic [tor_pkg::TIME_W-1:0] peak_ms;
    logic [tor_pkg::TIME_W-1:0] ticks;
    logic [tor_pkg::TIME_W-1:0] last_tap_ms;
    logic                       tap_is_open;
    logic                       rec_on;
    logic                       tap_seen;
    logic                       taps_ready;
    logic                       play_on;

    tor_pkg::result_t recorder_out_q[$];

    int  items_sent;
    int  results_seen;
    int  taps_seen;
    int  loops_closed;
    int  stops_seen;
    int  mismatches;
    int  stall_left;
    bit  idle_on;

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tap_onset_peak_recorder test failed");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    function automatic logic [tor_pkg::TIME_W-1:0] now_ms();
        logic [tor_pkg::PROD_W-1:0] prod;
        prod = tor_pkg::PROD_W'(ticks) * tor_pkg::PROD_W'(regs.tick_ms);
        return (prod > tor_pkg::PROD_W'(tor_pkg::TIME_MAX)) ? tor_pkg::TIME_MAX
                                                             : prod[tor_pkg::TIME_W-1:0];
    endfunction

    task automatic reset_recorder_state();
        regs.on_level    = tor_pkg::ON_LEVEL_RST;
        regs.off_level   = tor_pkg::OFF_LEVEL_RST;
        regs.tick_ms     = tor_pkg::TICK_MS_RST;
        regs.silence_ms  = tor_pkg::SILENCE_MS_RST;
        regs.loop_pad_ms = tor_pkg::LOOP_PAD_MS_RST;
        held_smp    = '0;
        peak_val    = '0;
        peak_ms     = '0;
        ticks       = '0;
        last_tap_ms = '0;
        tap_is_open = 1'b0;
        rec_on      = 1'b0;
        tap_seen    = 1'b0;
        taps_ready  = 1'b0;
        play_on     = 1'b0;
    endtask

    function automatic tor_pkg::result_t recorder_step(input tor_pkg::item_t it);
        tor_pkg::result_t           r;
        logic [7:0]                 s;
        logic [tor_pkg::TIME_W-1:0] cur;
        logic [tor_pkg::TIME_W:0]   padded;
        r = '0;
        if (it.cmd) begin
            // rhythm received: forget taps, keep recording and open tap
            play_on     = 1'b1;
            tap_seen    = 1'b0;
            last_tap_ms = '0;
            ticks       = '0;
            taps_ready  = 1'b0;
        end else begin
            if (it.sample_valid)
                held_smp = it.sample;
            s = held_smp;
            if (s > regs.on_level && !tap_is_open) begin
                tap_is_open = 1'b1;
                peak_val    = '0;
                if (!rec_on) begin
                    rec_on           = 1'b1;
                    play_on          = 1'b0;
                    r.stop_request   = 1'b1;
                end
            end
            if (tap_is_open && peak_val < s) begin
                peak_val = s;
                peak_ms  = now_ms();
            end
            if (s < regs.off_level && tap_is_open) begin
                tap_is_open = 1'b0;
                if (rec_on) begin
                    // first tap of a take rebases time
                    if (!tap_seen) begin
                        ticks   = '0;
                        peak_ms = '0;
                    end
                    r.tap_valid    = 1'b1;
                    r.tap_strength = 4'(peak_val / STRENGTH_DIV);
                    r.tap_time     = peak_ms;
                    tap_seen       = 1'b1;
                    last_tap_ms    = peak_ms;
                end
            end
            if (rec_on && tap_seen) begin
                cur = now_ms();
                if (cur > last_tap_ms && (cur - last_tap_ms) > regs.silence_ms) begin
                    taps_ready    = 1'b1;
                    rec_on        = 1'b0;
                    r.record_done = 1'b1;
                    padded = {1'b0, last_tap_ms} + (tor_pkg::TIME_W+1)'(regs.loop_pad_ms);
                    r.loop_length = (padded > tor_pkg::TIME_MAX) ? tor_pkg::TIME_MAX
                                                                 : padded[tor_pkg::TIME_W-1:0];
                end
            end
            if (rec_on && ticks < tor_pkg::TIME_MAX)
                ticks = ticks + 1'b1;
        end
        r.recording_now = rec_on;
        r.ready_now     = taps_ready;
        r.playing_now   = play_on;
        return r;
    endfunction

    task automatic send_req(input logic cmd, input logic sv, input logic [7:0] smp);
        int               gap;
        tor_pkg::item_t   it;
        tor_pkg::result_t exp_r;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_sample_valid <= sv;
        s_sample       <= smp;
        do @(posedge aclk); while (!s_ready);
        it.cmd          = cmd;
        it.sample_valid = sv;
        it.sample       = smp;
        exp_r = recorder_step(it);
        recorder_out_q = {recorder_out_q, exp_r};
        items_sent++;
    endtask

    // holds the sender until every predicted result has been checked
    task automatic wait_idle();
        @(negedge aclk) s_valid <= 1'b0;
        while (recorder_out_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input tor_pkg::cfg_idx_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        unique case (idx)
            tor_pkg::REG_ON_LEVEL:    regs.on_level    = val[7:0];
            tor_pkg::REG_OFF_LEVEL:   regs.off_level   = val[7:0];
            tor_pkg::REG_TICK_MS:     regs.tick_ms     = val[7:0];
            tor_pkg::REG_SILENCE_MS:  regs.silence_ms  = val;
            tor_pkg::REG_LOOP_PAD_MS: regs.loop_pad_ms = val;
            default: ;
        endcase
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    task automatic program_regs(input logic [7:0] on_v, input logic [7:0] off_v,
                                input logic [7:0] tick_v, input logic [15:0] sil_v,
                                input logic [15:0] pad_v);
        write_reg(tor_pkg::REG_ON_LEVEL, 16'(on_v));
        write_reg(tor_pkg::REG_OFF_LEVEL, 16'(off_v));
        write_reg(tor_pkg::REG_TICK_MS, 16'(tick_v));
        write_reg(tor_pkg::REG_SILENCE_MS, sil_v);
        write_reg(tor_pkg::REG_LOOP_PAD_MS, pad_v);
    endtask

    task automatic check_field(input string fname, input logic [tor_pkg::TIME_W-1:0] want,
                               input logic [tor_pkg::TIME_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s of result %0d: expected %0d, got %0d",
                         fname, results_seen, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_results
        tor_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_tap_valid)    taps_seen++;
            if (m_record_done)  loops_closed++;
            if (m_stop_request) stops_seen++;
            if (recorder_out_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing predicted", results_seen);
            end else begin
                want = recorder_out_q.pop_front();
                check_field("stop_request", tor_pkg::TIME_W'(want.stop_request),
                            tor_pkg::TIME_W'(m_stop_request));
                check_field("tap_valid", tor_pkg::TIME_W'(want.tap_valid),
                            tor_pkg::TIME_W'(m_tap_valid));
                check_field("tap_strength", tor_pkg::TIME_W'(want.tap_strength),
                            tor_pkg::TIME_W'(m_tap_strength));
                check_field("tap_time", want.tap_time, m_tap_time);
                check_field("record_done", tor_pkg::TIME_W'(want.record_done),
                            tor_pkg::TIME_W'(m_record_done));
                check_field("loop_length", want.loop_length, m_loop_length);
                check_field("recording_now", tor_pkg::TIME_W'(want.recording_now),
                            tor_pkg::TIME_W'(m_recording_now));
                check_field("ready_now", tor_pkg::TIME_W'(want.ready_now),
                            tor_pkg::TIME_W'(m_ready_now));
                check_field("playing_now", tor_pkg::TIME_W'(want.playing_now),
                            tor_pkg::TIME_W'(m_playing_now));
            end
        end
    end

    // output side back-pressure
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic test_default_regs();
        send_req(1'b0, 1'b1, 8'd0);
        send_req(1'b0, 1'b1, 8'd30);     // equal to threshold: nothing opens
        send_req(1'b0, 1'b1, 8'd31);     // opens, starts the take
        send_req(1'b0, 1'b1, 8'd255);
        send_req(1'b1, 1'b1, 8'hAA);     // clear with a tap still open
        send_req(1'b0, 1'b1, 8'd30);     // equal to threshold: stays open
        send_req(1'b0, 1'b1, 8'd29);     // closes, first tap rebases time
        send_req(1'b0, 1'b0, 8'hFF);
        send_req(1'b0, 1'b1, 8'd0);
    endtask

    task automatic test_single_tick_taps();
        wait_idle();
        program_regs(8'd10, 8'd200, 8'd1, 16'd0, 16'd0);
        send_req(1'b1, 1'b0, 8'h55);
        send_req(1'b0, 1'b1, 8'd100);    // rise and fall in the same tick
        send_req(1'b0, 1'b0, 8'd0);      // held sample taps again, time equals last tap
        send_req(1'b0, 1'b1, 8'd5);      // silence exceeded, take ends
        wait_idle();
        program_regs(8'd10, 8'd5, 8'd1, 16'd0, 16'd0);
        send_req(1'b0, 1'b1, 8'd100);    // new take with old taps ends at once
        send_req(1'b0, 1'b1, 8'd0);      // close outside a take, no tap
        wait_idle();
        program_regs(8'd255, 8'd0, 8'd1, 16'd0, 16'd0);
        send_req(1'b0, 1'b1, 8'd255);
        send_req(1'b0, 1'b1, 8'd0);
    endtask

    task automatic test_long_take();
        int n;
        wait_idle();
        idle_on = 1'b0;
        program_regs(8'd100, 8'd50, 8'd255, 16'hFFFF, 16'hFFFF);
        send_req(1'b1, 1'b0, 8'd0);
        // widely spaced taps with the largest tick and pad
        for (n = 0; n < 4; n++) begin
            repeat (40) send_req(1'b0, 1'b0, 8'd0);
            send_req(1'b0, 1'b1, 8'd200);
            send_req(1'b0, 1'b1, 8'd0);
        end
        wait_idle();
        write_reg(tor_pkg::REG_SILENCE_MS, 16'd1000);
        for (n = 0; n < 20 && rec_on; n++)
            send_req(1'b0, 1'b0, 8'd0);
        send_req(1'b1, 1'b0, 8'd0);
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic send_tap_burst(input int quiet);
        if (regs.on_level == 8'd255)
            send_req(1'b0, 1'b1, 8'($urandom_range(0, 255)));
        else
            send_req(1'b0, 1'b1, 8'($urandom_range(regs.on_level + 1, 255)));
        repeat ($urandom_range(0, 3))
            send_req(1'b0, 1'($urandom_range(0, 1)),
                     8'($urandom_range(regs.off_level, 255)));
        if (regs.off_level != 8'd0)
            send_req(1'b0, 1'b1, 8'($urandom_range(0, regs.off_level - 1)));
        repeat ($urandom_range(0, quiet))
            send_req(1'b0, 1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic();
        int         ph;
        int         phase_end;
        int         quiet;
        int         kind;
        int         sil_i;
        logic [7:0] on_v;
        logic [7:0] off_v;
        logic [7:0] tick_v;
        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: program_regs(8'd0, 8'd255, 8'd1, 16'd0, 16'd0);
                1: program_regs(8'd254, 8'd1, 8'd255, 16'hFFFF, 16'hFFFF);
                default: begin
                    on_v   = 8'($urandom_range(20, 220));
                    off_v  = 8'($urandom_range(0, on_v));
                    tick_v = 8'($urandom_range(1, 255));
                    sil_i  = int'(tick_v * $urandom_range(1, 30) + $urandom_range(0, 255));
                    if (sil_i > 65535) sil_i = 65535;
                    program_regs(on_v, off_v, tick_v, 16'(sil_i), 16'($urandom));
                end
            endcase
            idle_on = (ph != 2);
            quiet = int'(regs.silence_ms / regs.tick_ms) + 4;
            if (quiet > 40) quiet = 40;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                kind = int'($urandom_range(0, 99));
                if (kind < 70)
                    send_tap_burst(quiet);
                else if (kind < 80)
                    send_req(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                else
                    send_req(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 29) == 0)
                    wait_idle();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = 1'b0;
        s_sample_valid = 1'b0;
        s_sample       = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        items_sent     = 0;
        results_seen   = 0;
        taps_seen      = 0;
        loops_closed   = 0;
        stops_seen     = 0;
        mismatches     = 0;
        idle_on        = 1'b1;
        reset_recorder_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_default_regs();
        test_single_tick_taps();
        test_long_take();
        test_random_traffic();
        wait_idle();

        $display("sent %0d requests and checked %0d results: default registers,",
                 items_sent, results_seen);
        $display("single-tick taps, a long take and six random phases; %0d taps, %0d takes, %0d stops, %0d mismatches",
                 taps_seen, loops_closed, stops_seen, mismatches);
        if (mismatches == 0 && recorder_out_q.size() == 0)
            $display("tap_onset_peak_recorder test passed");
        else
            $display("tap_onset_peak_recorder test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tor_pkg.sv
rtl/tor_cfg.sv
rtl/tor_step.sv
rtl/tor_out_reg.sv
rtl/tap_onset_peak_recorder.sv
bench/tb_tap_onset_peak_recorder.sv
